// ----- rtl/core/tih_pkg.sv -----
// ----------------------------------------------------------------------------
// Turn indicator and hazard controller package
// Shared mode codes, register indexes and the lamp drive bundle.
// ----------------------------------------------------------------------------
package tih_pkg;

    localparam int unsigned MODE_W = 2;
    localparam int unsigned PRESS_W = 16;
    localparam int unsigned BLINK_W = 8;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_OFF = 2'd0;
    localparam mode_t MODE_LEFT = 2'd1;
    localparam mode_t MODE_RIGHT = 2'd2;
    localparam mode_t MODE_HAZARD = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_TICKS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_TICKS = 1'b1;

    // Lamp drive levels as seen on the result word.
    typedef struct packed {
        logic left_drive;
        logic right_drive;
    } lamp_drive_t;

endpackage

// ----- rtl/core/tih_button_timer.sv -----
// ----------------------------------------------------------------------------
// Button press timer
// Times one button from its rising edge and flags a qualifying release.
// ----------------------------------------------------------------------------
module tih_button_timer
    import tih_pkg::*;
#(
    parameter int unsigned HOLD_COUNT_WIDTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               level,
    input  logic [PRESS_W-1:0] press_ticks,
    output logic               fired
);

    localparam int unsigned CMP_W = (HOLD_COUNT_WIDTH > PRESS_W) ? HOLD_COUNT_WIDTH : PRESS_W;
    localparam logic [HOLD_COUNT_WIDTH-1:0] HOLD_MAX = '1;

    logic                        prev_reg;
    logic                        prev_next;
    logic [HOLD_COUNT_WIDTH-1:0] count_reg;
    logic [HOLD_COUNT_WIDTH-1:0] count_next;
    logic [HOLD_COUNT_WIDTH-1:0] count_inc;

    // Saturating increment of the hold count.
    assign count_inc = (count_reg == HOLD_MAX) ? HOLD_MAX : count_reg + 1'b1;

    always_comb
    begin
        prev_next = level;
        count_next = count_reg;
        fired = 1'b0;
        if (level && !prev_reg)
        begin
            count_next = '0;
        end
        else if (prev_reg)
        begin
            count_next = count_inc;
            fired = !level && (CMP_W'(count_inc) >= CMP_W'(press_ticks));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= 1'b0;
            count_reg <= '0;
        end
        else if (step)
        begin
            prev_reg <= prev_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/core/tih_hazard_timer.sv -----
// ----------------------------------------------------------------------------
// Hazard hold timer
// Times how long both buttons are held together and flags hazard entry.
// ----------------------------------------------------------------------------
module tih_hazard_timer
    import tih_pkg::*;
#(
    parameter int unsigned HOLD_COUNT_WIDTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               both_held,
    input  logic [PRESS_W-1:0] press_ticks,
    output logic               hit
);

    localparam int unsigned CMP_W = (HOLD_COUNT_WIDTH > PRESS_W) ? HOLD_COUNT_WIDTH : PRESS_W;
    localparam logic [HOLD_COUNT_WIDTH-1:0] HOLD_MAX = '1;

    logic                        armed_reg;
    logic                        armed_next;
    logic [HOLD_COUNT_WIDTH-1:0] count_reg;
    logic [HOLD_COUNT_WIDTH-1:0] count_next;
    logic [HOLD_COUNT_WIDTH-1:0] count_inc;

    assign count_inc = (count_reg == HOLD_MAX) ? HOLD_MAX : count_reg + 1'b1;

    // The first tick of a joint hold arms the timer; any tick without both
    // buttons held disarms it again.
    always_comb
    begin
        armed_next = both_held;
        count_next = '0;
        hit = 1'b0;
        if (both_held && armed_reg)
        begin
            count_next = count_inc;
            hit = CMP_W'(count_inc) >= CMP_W'(press_ticks);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            count_reg <= '0;
        end
        else if (step)
        begin
            armed_reg <= armed_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/core/tih_lamp_sequencer.sv -----
// ----------------------------------------------------------------------------
// Lamp sequencer
// Counts blink intervals and toggles the lamp levels for the current mode.
// ----------------------------------------------------------------------------
module tih_lamp_sequencer
    import tih_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  mode_t              mode,
    input  logic [BLINK_W-1:0] blink_ticks,
    output lamp_drive_t        drive_next
);

    logic [BLINK_W-1:0] blink_count_reg;
    logic [BLINK_W-1:0] blink_count_next;
    logic [BLINK_W-1:0] blink_count_inc;
    logic               left_level_reg;
    logic               left_level_next;
    logic               right_level_reg;
    logic               right_level_next;
    lamp_drive_t        drive_reg;

    assign blink_count_inc = blink_count_reg + 1'b1;

    always_comb
    begin
        blink_count_next = blink_count_inc;
        left_level_next = left_level_reg;
        right_level_next = right_level_reg;
        drive_next = drive_reg;
        if (blink_count_inc >= blink_ticks)
        begin
            blink_count_next = '0;
            unique case (mode)
                MODE_LEFT:
                begin
                    left_level_next = !left_level_reg;
                    drive_next.left_drive = !left_level_reg;
                    drive_next.right_drive = 1'b0;
                end
                MODE_RIGHT:
                begin
                    right_level_next = !right_level_reg;
                    drive_next.left_drive = 1'b0;
                    drive_next.right_drive = !right_level_reg;
                end
                MODE_HAZARD:
                begin
                    left_level_next = !left_level_reg;
                    right_level_next = !left_level_reg;
                    drive_next.left_drive = !left_level_reg;
                    drive_next.right_drive = !left_level_reg;
                end
                default:
                begin
                    left_level_next = 1'b0;
                    right_level_next = 1'b0;
                    drive_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_count_reg <= '0;
            left_level_reg <= 1'b0;
            right_level_reg <= 1'b0;
            drive_reg <= '0;
        end
        else if (step)
        begin
            blink_count_reg <= blink_count_next;
            left_level_reg <= left_level_next;
            right_level_reg <= right_level_next;
            drive_reg <= drive_next;
        end
    end

endmodule

// ----- rtl/core/turn_indicator_hazard_controller_core.sv -----
// Path: a tick word accepted into the input register moves on to the result register
// once that register is free, and its result word is offered from there.
// Throughput: one tick word per cycle unless the result stream stalls; the per-tick
// update is one short pass of logic between the input register and the result register.
// Reset: rst_n clears mode, timers, lamp state and both valid flags at once;
// the registers return to press_ticks = 10 and blink_ticks = 3.
// ----------------------------------------------------------------------------
// Turn indicator and hazard controller core
// Times the left and right buttons per scheduler tick, selects the indicator
// mode and produces the blinking lamp drives.
// ----------------------------------------------------------------------------
module turn_indicator_hazard_controller_core
    import tih_pkg::*;
#(
    parameter int unsigned HOLD_COUNT_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Tick input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [0] left_pressed, [1] right_pressed, [7:2] zero
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [1:0] indicator_mode, [2] left_lamp,
                                              // [3] right_lamp, [7:4] zero
    // Register write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Register file. Writes are always taken: the user must make them happen only while idle.
    logic [PRESS_W-1:0] press_ticks_reg;
    logic [BLINK_W-1:0] blink_ticks_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_ticks_reg <= PRESS_W'(10);
            blink_ticks_reg <= BLINK_W'(3);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PRESS_TICKS: press_ticks_reg <= cfg_data;
                CFG_BLINK_TICKS: blink_ticks_reg <= cfg_data[BLINK_W-1:0];
                default:         ;
            endcase
        end
    end

    // Pipeline control. The result register frees up when its word is taken,
    // so the input register can advance in the same cycle; the input side is
    // ready whenever its register is empty or advancing.
    logic  in_valid_reg;
    logic  left_reg;
    logic  right_reg;
    logic  out_valid_reg;
    logic  out_free;
    logic  advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            left_reg <= s_tdata[0];
            right_reg <= s_tdata[1];
        end
    end

    // Per-tick update. The state registers in the submodules move only when
    // a tick leaves the input register for the result register.
    logic        left_fired;
    logic        right_fired;
    logic        hazard_hit;
    mode_t       mode_reg;
    mode_t       mode_after_left;
    mode_t       mode_after_right;
    mode_t       mode_next;
    lamp_drive_t drive_next;

    tih_button_timer #(
        .HOLD_COUNT_WIDTH (HOLD_COUNT_WIDTH)
    ) u_left_timer (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .level       (left_reg),
        .press_ticks (press_ticks_reg),
        .fired       (left_fired)
    );

    tih_button_timer #(
        .HOLD_COUNT_WIDTH (HOLD_COUNT_WIDTH)
    ) u_right_timer (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .level       (right_reg),
        .press_ticks (press_ticks_reg),
        .fired       (right_fired)
    );

    tih_hazard_timer #(
        .HOLD_COUNT_WIDTH (HOLD_COUNT_WIDTH)
    ) u_hazard_timer (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .both_held   (left_reg && right_reg),
        .press_ticks (press_ticks_reg),
        .hit         (hazard_hit)
    );

    // The left press is applied first, then the right press, then the hazard
    // hold. A lone press from hazard returns to off.
    always_comb
    begin
        mode_after_left = mode_reg;
        if (left_fired)
        begin
            mode_after_left = (mode_reg == MODE_OFF || mode_reg == MODE_RIGHT) ?
                              MODE_LEFT : MODE_OFF;
        end
        mode_after_right = mode_after_left;
        if (right_fired)
        begin
            mode_after_right = (mode_after_left == MODE_OFF ||
                                mode_after_left == MODE_LEFT) ? MODE_RIGHT : MODE_OFF;
        end
        mode_next = hazard_hit ? MODE_HAZARD : mode_after_right;
    end

    tih_lamp_sequencer u_lamps (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .mode        (mode_next),
        .blink_ticks (blink_ticks_reg),
        .drive_next  (drive_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_OFF;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
        end
    end

    // Result register.
    mode_t       out_mode_reg;
    lamp_drive_t out_drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_mode_reg <= mode_next;
            out_drive_reg <= drive_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {4'b0000, out_drive_reg.right_drive, out_drive_reg.left_drive,
                      out_mode_reg};

endmodule

// ----- rtl/core/tih_checker.sv -----
// ----------------------------------------------------------------------------
// Turn indicator and hazard controller checker
// Port-level properties of the core, attached to it by a bind statement.
// ----------------------------------------------------------------------------
module tih_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // With the result register empty, the input side never stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // The padding bits of a result word are always zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:4] == 4'b0000)
        else $error("nonzero padding in result word");

    // A fresh result word needs a tick taken earlier through the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result word without a tick");

endmodule

bind turn_indicator_hazard_controller_core tih_checker u_tih_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
